// File: rtl/pot_pkg.sv
// Shared types, constants and fixed-point helpers for the planar odometry PD tracker.
package pot_pkg;

  localparam int TRIG_BITS  = 10;
  localparam int TRIG_DEPTH = 1 << TRIG_BITS;
  localparam int TRIG_QUAD  = TRIG_DEPTH / 4;
  localparam int TRIG_HALF  = TRIG_DEPTH / 2;

  localparam int SCALE_X    = 256;
  localparam int SCALE_Y    = 256;
  localparam int SCALE_TURN = 256;

  localparam longint PIH_Q30 = 64'sd1686629713;

  localparam int CFG_IW = 3;
  localparam int CFG_DW = 16;
  localparam logic [CFG_IW-1:0] CFG_GAIN_P_X    = CFG_IW'(0);
  localparam logic [CFG_IW-1:0] CFG_GAIN_D_X    = CFG_IW'(1);
  localparam logic [CFG_IW-1:0] CFG_GAIN_P_Y    = CFG_IW'(2);
  localparam logic [CFG_IW-1:0] CFG_GAIN_D_Y    = CFG_IW'(3);
  localparam logic [CFG_IW-1:0] CFG_GAIN_P_TURN = CFG_IW'(4);
  localparam logic [CFG_IW-1:0] CFG_GAIN_D_TURN = CFG_IW'(5);
  localparam logic [CFG_IW-1:0] CFG_TICK_PERIOD = CFG_IW'(6);
  localparam logic [CFG_DW-1:0] TICK_RESET      = CFG_DW'(66);

  localparam int MUL_AW = 52;
  localparam int MUL_BW = 18;
  localparam int MUL_PW = 70;
  localparam int MUL_CW = $clog2(MUL_BW - 1);
  localparam int DIV_AW = 64;
  localparam int DIV_BW = 25;
  localparam int DIV_CW = $clog2(DIV_AW);

  localparam int EW = 72;
  typedef logic signed [EW-1:0] ext_t;

  localparam ext_t I32_MAX  = ext_t'(64'sd2147483647);
  localparam ext_t I32_MIN  = ext_t'(-64'sd2147483648);
  localparam ext_t C24_MAX  = ext_t'(8388607);
  localparam ext_t C24_MIN  = ext_t'(-8388608);
  localparam ext_t C40_MAX  = ext_t'(64'sd1099511627776);
  localparam ext_t C40_MIN  = ext_t'(-64'sd1099511627776);
  localparam ext_t DEG5     = ext_t'(5 * 65536);
  localparam ext_t DEG180   = ext_t'(180 * 65536);
  localparam ext_t DEG360   = ext_t'(360 * 65536);
  localparam ext_t HALF16   = ext_t'(32768);
  localparam ext_t HALF32   = ext_t'(64'sd2147483648);
  localparam ext_t YAW_BIAS = ext_t'(50);
  localparam ext_t BLEND_BIAS = ext_t'(2);
  localparam logic [DIV_BW-1:0] DIV_DEG360 = DIV_BW'(360 * 65536);
  localparam logic [DIV_BW-1:0] DIV_YAW    = DIV_BW'(100);
  localparam logic [DIV_BW-1:0] DIV_BLEND  = DIV_BW'(5);

  typedef enum logic [4:0] {
    ST_IDLE, ST_IDX1, ST_LOOK1, ST_VXC, ST_VYS, ST_TDX, ST_VYC, ST_VXS, ST_TDY,
    ST_YAW, ST_VZD, ST_BLEND, ST_SNAP, ST_ERR, ST_IDX2, ST_LOOK2, ST_KP, ST_KD,
    ST_DDIV, ST_FXC, ST_FYS, ST_FYC, ST_FXS, ST_FIN
  } st_t;

  typedef struct packed {
    logic              start;
    logic [MUL_AW-1:0] a;
    logic [MUL_BW-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic              done;
    logic [MUL_PW-1:0] p;
  } mul_rsp_t;

  typedef struct packed {
    logic              start;
    logic [DIV_AW-1:0] a;
    logic [DIV_BW-1:0] b;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIV_AW-1:0] q;
  } div_rsp_t;

  typedef logic [16:0] trig_tab_t [0:TRIG_QUAD];

  function automatic longint shift_sub_div(input longint num, input longint den);
    longint quo;
    longint rem;
    quo = 0;
    rem = 0;
    for (int i = 62; i >= 0; i--) begin
      rem = (rem <<< 1) | ((num >>> i) & 64'sd1);
      quo = quo <<< 1;
      if (rem >= den) begin
        rem = rem - den;
        quo = quo | 64'sd1;
      end
    end
    return quo;
  endfunction

  function automatic trig_tab_t build_trig();
    trig_tab_t tab;
    longint    x;
    longint    term;
    longint    sum;
    longint    p;
    for (int k = 0; k <= TRIG_QUAD; k++) begin
      p = longint'(k) <<< (32 - TRIG_BITS);
      x = (p * PIH_Q30) >>> 30;
      sum = x;
      term = x;
      for (int n = 1; n <= 6; n++) begin
        term = (((term * x) >>> 30) * x) >>> 30;
        term = shift_sub_div(term, longint'((2 * n) * (2 * n + 1)));
        if (n[0]) sum = sum - term;
        else sum = sum + term;
      end
      sum = (sum + 64'sd8192) >>> 14;
      tab[k] = 17'(sum);
    end
    return tab;
  endfunction

  localparam trig_tab_t TRIG_TAB = build_trig();

  function automatic logic signed [17:0] sin_at(input logic [TRIG_BITS-1:0] k);
    logic [TRIG_BITS-2:0] f;
    logic signed [17:0]   mag;
    f = k[TRIG_BITS-2:0];
    if (int'(f) > TRIG_QUAD) f = (TRIG_BITS-1)'(TRIG_HALF - int'(f));
    mag = signed'({1'b0, TRIG_TAB[f]});
    return k[TRIG_BITS-1] ? -mag : mag;
  endfunction

  function automatic logic signed [31:0] sat32(input ext_t v);
    priority if (v > I32_MAX) return 32'(I32_MAX);
    else if (v < I32_MIN) return 32'(I32_MIN);
    else return 32'(v);
  endfunction

  function automatic logic signed [23:0] clamp24(input ext_t v);
    priority if (v > C24_MAX) return 24'(C24_MAX);
    else if (v < C24_MIN) return 24'(C24_MIN);
    else return 24'(v);
  endfunction

  function automatic logic signed [41:0] clamp40(input ext_t v);
    priority if (v > C40_MAX) return 42'(C40_MAX);
    else if (v < C40_MIN) return 42'(C40_MIN);
    else return 42'(v);
  endfunction

endpackage

// File: rtl/pot_mul.sv
// Shift-add serial multiplier, one multiplier bit per cycle.
module pot_mul (
  input  logic               clk,
  input  logic               rst_n,
  input  pot_pkg::mul_req_t  req,
  output pot_pkg::mul_rsp_t  rsp
);

  logic                                busy_r;
  logic                                done_r;
  logic [pot_pkg::MUL_CW-1:0]          cnt_r;
  logic signed [pot_pkg::MUL_PW-1:0]   acc_r;
  logic signed [pot_pkg::MUL_PW-1:0]   ash_r;
  logic [pot_pkg::MUL_BW-2:0]          bm_r;
  logic signed [pot_pkg::MUL_BW-1:0]   b_in;
  logic signed [pot_pkg::MUL_BW-1:0]   b_abs;
  logic signed [pot_pkg::MUL_PW-1:0]   a_ext;
  logic signed [pot_pkg::MUL_PW-1:0]   a_load;

  always_comb begin
    b_in   = signed'(req.b);
    b_abs  = b_in[pot_pkg::MUL_BW-1] ? -b_in : b_in;
    a_ext  = pot_pkg::MUL_PW'(signed'(req.a));
    a_load = b_in[pot_pkg::MUL_BW-1] ? -a_ext : a_ext;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= pot_pkg::MUL_CW'(pot_pkg::MUL_BW - 2);
      end else if (busy_r) begin
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      acc_r <= '0;
      ash_r <= a_load;
      bm_r  <= b_abs[pot_pkg::MUL_BW-2:0];
    end else if (busy_r) begin
      if (bm_r[0]) acc_r <= acc_r + ash_r;
      ash_r <= ash_r <<< 1;
      bm_r  <= bm_r >> 1;
    end
  end

  assign rsp.done = done_r;
  assign rsp.p    = acc_r;

endmodule

// File: rtl/pot_div.sv
// Restoring serial divider with floor rounding, one quotient bit per cycle.
module pot_div (
  input  logic               clk,
  input  logic               rst_n,
  input  pot_pkg::div_req_t  req,
  output pot_pkg::div_rsp_t  rsp
);

  logic                             busy_r;
  logic                             fin_r;
  logic                             done_r;
  logic [pot_pkg::DIV_CW-1:0]       cnt_r;
  logic                             neg_r;
  logic [pot_pkg::DIV_AW-1:0]       q_r;
  logic [pot_pkg::DIV_BW-1:0]       rem_r;
  logic [pot_pkg::DIV_BW-1:0]       b_r;
  logic [pot_pkg::DIV_AW-1:0]       res_r;
  logic [pot_pkg::DIV_BW:0]         trial;
  logic                             ge;

  always_comb begin
    trial = {rem_r, q_r[pot_pkg::DIV_AW-1]};
    ge    = trial >= {1'b0, b_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      fin_r  <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= pot_pkg::DIV_CW'(pot_pkg::DIV_AW - 1);
      end else if (busy_r) begin
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          fin_r  <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end else if (fin_r) begin
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      neg_r <= req.a[pot_pkg::DIV_AW-1];
      q_r   <= req.a[pot_pkg::DIV_AW-1] ? -req.a : req.a;
      rem_r <= '0;
      b_r   <= req.b;
    end else if (busy_r) begin
      rem_r <= ge ? pot_pkg::DIV_BW'(trial - {1'b0, b_r}) : pot_pkg::DIV_BW'(trial);
      q_r   <= {q_r[pot_pkg::DIV_AW-2:0], ge};
    end else if (fin_r) begin
      res_r <= neg_r ? -(q_r + pot_pkg::DIV_AW'(rem_r != '0)) : q_r;
    end
  end

  assign rsp.done = done_r;
  assign rsp.q    = res_r;

endmodule

// File: rtl/planar_odometry_pd_tracker.sv
// Top level of the planar odometry PD tracker: sequencer, state and shared serial units.
// Set-target transaction: accepted in idle without leaving it, no result.
// Tick transaction: 7 divisions, 17 multiplications and 5 steps that use neither serial
// unit; the next accept comes once the result is registered and the sequencer is idle again.
// The serial divider (one quotient bit per cycle over 64 bits) takes most of a tick's time.
// Synchronous active-low reset clears position, heading, goals, previous errors and gains; no sweep.
module planar_odometry_pd_tracker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [pot_pkg::CFG_IW-1:0]          cfg_index,
  input  logic [pot_pkg::CFG_DW-1:0]          cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_operation,
  input  logic signed [15:0]                  in_wheel_speed_0,
  input  logic signed [15:0]                  in_wheel_speed_1,
  input  logic signed [15:0]                  in_wheel_speed_2,
  input  logic signed [15:0]                  in_wheel_speed_3,
  input  logic signed [15:0]                  in_gyro_yaw,
  input  logic signed [31:0]                  in_target_x,
  input  logic signed [31:0]                  in_target_y,
  input  logic signed [31:0]                  in_target_heading,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [23:0]                  out_cmd_speed_x,
  output logic signed [23:0]                  out_cmd_speed_y,
  output logic signed [23:0]                  out_cmd_speed_turn,
  output logic signed [31:0]                  out_pos_x,
  output logic signed [31:0]                  out_pos_y,
  output logic signed [31:0]                  out_heading
);

  localparam int TW = 36;
  localparam int FW = 42;
  localparam logic [1:0] AX_LAST = 2'd2;

  pot_pkg::st_t       state_r, state_nxt;
  pot_pkg::mul_req_t  mul_req;
  pot_pkg::mul_rsp_t  mul_rsp;
  pot_pkg::div_req_t  div_req;
  pot_pkg::div_rsp_t  div_rsp;

  logic                 launched_r;
  logic [1:0]           ax_r;
  logic                 out_valid_r;
  logic [15:0]          kpx_r, kdx_r, kpy_r, kdy_r, kpz_r, kdz_r, tick_r;
  logic signed [31:0]   est_x_r, est_y_r, est_h_r, last_yaw_r;
  logic signed [31:0]   goal_x_r, goal_y_r, goal_h_r;
  logic signed [31:0]   prev_x_r, prev_y_r, prev_h_r;

  logic signed [31:0]   vx_r, vy_r, vz_r;
  logic signed [15:0]   yaw_r;
  logic [pot_pkg::TRIG_BITS-1:0] idx_r;
  logic signed [17:0]   c_r, s_r;
  logic signed [pot_pkg::MUL_PW-1:0] p1_r;
  logic signed [TW-1:0] t_r, nxt_r, h_r;
  logic signed [31:0]   ex_r, ey_r, ez_r;
  logic signed [FW-1:0] pt_r;
  logic signed [FW-1:0] f_r [0:2];
  logic signed [23:0]   rx_r, ry_r;
  logic signed [23:0]   ocx_r, ocy_r, ocz_r;
  logic signed [31:0]   opx_r, opy_r, oph_r;

  logic                 in_fire, out_free, is_mul, is_div, op_done;
  logic signed [17:0]   sum_x, sum_y, sum_z;
  logic [15:0]          dt, kp_sel, kd_sel;
  logic signed [31:0]   e_sel, prev_sel;
  logic signed [32:0]   diff;
  logic signed [pot_pkg::MUL_PW-1:0] prod;
  logic signed [pot_pkg::DIV_AW-1:0] quo;
  pot_pkg::ext_t        yaw_d, yaw_unw, snap_d, h_snap;

  assign in_stall  = !rst_n || (state_r != pot_pkg::ST_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign prod      = signed'(mul_rsp.p);
  assign quo       = signed'(div_rsp.q);

  always_comb begin
    sum_x = 18'(in_wheel_speed_0) + 18'(in_wheel_speed_1)
          + 18'(in_wheel_speed_2) + 18'(in_wheel_speed_3);
    sum_y = 18'(in_wheel_speed_0) - 18'(in_wheel_speed_1)
          - 18'(in_wheel_speed_2) + 18'(in_wheel_speed_3);
    sum_z = 18'(in_wheel_speed_0) - 18'(in_wheel_speed_1)
          + 18'(in_wheel_speed_2) - 18'(in_wheel_speed_3);
    dt = (tick_r == '0) ? 16'd1 : tick_r;
    unique case (ax_r)
      2'd0: begin
        kp_sel = kpx_r; kd_sel = kdx_r; e_sel = ex_r; prev_sel = prev_x_r;
      end
      2'd1: begin
        kp_sel = kpy_r; kd_sel = kdy_r; e_sel = ey_r; prev_sel = prev_y_r;
      end
      default: begin
        kp_sel = kpz_r; kd_sel = kdz_r; e_sel = ez_r; prev_sel = prev_h_r;
      end
    endcase
    diff = 33'(e_sel) - 33'(prev_sel);
    yaw_d = pot_pkg::ext_t'(quo) - pot_pkg::ext_t'(last_yaw_r);
    priority if (yaw_d < -pot_pkg::DEG180) yaw_unw = pot_pkg::ext_t'(quo) + pot_pkg::DEG360;
    else if (yaw_d > pot_pkg::DEG180) yaw_unw = pot_pkg::ext_t'(quo) - pot_pkg::DEG360;
    else yaw_unw = pot_pkg::ext_t'(quo);
    snap_d = pot_pkg::ext_t'(h_r) - pot_pkg::ext_t'(nxt_r);
    h_snap = (snap_d > pot_pkg::DEG5 || -snap_d > pot_pkg::DEG5) ?
             pot_pkg::ext_t'(nxt_r) : pot_pkg::ext_t'(h_r);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pot_pkg::ST_IDLE:  if (in_fire && !in_operation) state_nxt = pot_pkg::ST_IDX1;
      pot_pkg::ST_IDX1:  if (op_done) state_nxt = pot_pkg::ST_LOOK1;
      pot_pkg::ST_LOOK1: state_nxt = pot_pkg::ST_VXC;
      pot_pkg::ST_VXC:   if (op_done) state_nxt = pot_pkg::ST_VYS;
      pot_pkg::ST_VYS:   if (op_done) state_nxt = pot_pkg::ST_TDX;
      pot_pkg::ST_TDX:   if (op_done) state_nxt = pot_pkg::ST_VYC;
      pot_pkg::ST_VYC:   if (op_done) state_nxt = pot_pkg::ST_VXS;
      pot_pkg::ST_VXS:   if (op_done) state_nxt = pot_pkg::ST_TDY;
      pot_pkg::ST_TDY:   if (op_done) state_nxt = pot_pkg::ST_YAW;
      pot_pkg::ST_YAW:   if (op_done) state_nxt = pot_pkg::ST_VZD;
      pot_pkg::ST_VZD:   if (op_done) state_nxt = pot_pkg::ST_BLEND;
      pot_pkg::ST_BLEND: if (op_done) state_nxt = pot_pkg::ST_SNAP;
      pot_pkg::ST_SNAP:  state_nxt = pot_pkg::ST_ERR;
      pot_pkg::ST_ERR:   state_nxt = pot_pkg::ST_IDX2;
      pot_pkg::ST_IDX2:  if (op_done) state_nxt = pot_pkg::ST_LOOK2;
      pot_pkg::ST_LOOK2: state_nxt = pot_pkg::ST_KP;
      pot_pkg::ST_KP:    if (op_done) state_nxt = pot_pkg::ST_KD;
      pot_pkg::ST_KD:    if (op_done) state_nxt = pot_pkg::ST_DDIV;
      pot_pkg::ST_DDIV:  if (op_done) state_nxt = (ax_r == AX_LAST) ? pot_pkg::ST_FXC
                                                                     : pot_pkg::ST_KP;
      pot_pkg::ST_FXC:   if (op_done) state_nxt = pot_pkg::ST_FYS;
      pot_pkg::ST_FYS:   if (op_done) state_nxt = pot_pkg::ST_FYC;
      pot_pkg::ST_FYC:   if (op_done) state_nxt = pot_pkg::ST_FXS;
      pot_pkg::ST_FXS:   if (op_done) state_nxt = pot_pkg::ST_FIN;
      pot_pkg::ST_FIN:   if (out_free) state_nxt = pot_pkg::ST_IDLE;
      default:           state_nxt = pot_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    is_mul    = 1'b0;
    is_div    = 1'b0;
    mul_req.a = '0;
    mul_req.b = '0;
    div_req.a = '0;
    div_req.b = pot_pkg::DIV_YAW;
    unique case (state_r)
      pot_pkg::ST_IDX1, pot_pkg::ST_IDX2: begin
        is_div = 1'b1;
        div_req.a = pot_pkg::DIV_AW'((pot_pkg::ext_t'(est_h_r) <<< pot_pkg::TRIG_BITS)
                                     + pot_pkg::DEG180);
        div_req.b = pot_pkg::DIV_DEG360;
      end
      pot_pkg::ST_YAW: begin
        is_div = 1'b1;
        div_req.a = pot_pkg::DIV_AW'(-(pot_pkg::ext_t'(yaw_r) <<< 16) + pot_pkg::YAW_BIAS);
        div_req.b = pot_pkg::DIV_YAW;
      end
      pot_pkg::ST_BLEND: begin
        is_div = 1'b1;
        div_req.a = pot_pkg::DIV_AW'(pot_pkg::ext_t'(nxt_r) - pot_pkg::ext_t'(h_r)
                                     + pot_pkg::BLEND_BIAS);
        div_req.b = pot_pkg::DIV_BLEND;
      end
      pot_pkg::ST_DDIV: begin
        is_div = 1'b1;
        div_req.a = pot_pkg::DIV_AW'((pot_pkg::ext_t'(p1_r) <<< 8)
                                     + pot_pkg::ext_t'({1'b0, dt[15:1]}));
        div_req.b = pot_pkg::DIV_BW'(dt);
      end
      pot_pkg::ST_VXC: begin
        is_mul = 1'b1; mul_req.a = pot_pkg::MUL_AW'(vx_r); mul_req.b = c_r;
      end
      pot_pkg::ST_VYS: begin
        is_mul = 1'b1; mul_req.a = pot_pkg::MUL_AW'(vy_r); mul_req.b = s_r;
      end
      pot_pkg::ST_VYC: begin
        is_mul = 1'b1; mul_req.a = pot_pkg::MUL_AW'(vy_r); mul_req.b = c_r;
      end
      pot_pkg::ST_VXS: begin
        is_mul = 1'b1; mul_req.a = pot_pkg::MUL_AW'(vx_r); mul_req.b = s_r;
      end
      pot_pkg::ST_TDX, pot_pkg::ST_TDY: begin
        is_mul = 1'b1; mul_req.a = pot_pkg::MUL_AW'(t_r); mul_req.b = {2'b00, dt};
      end
      pot_pkg::ST_VZD: begin
        is_mul = 1'b1; mul_req.a = pot_pkg::MUL_AW'(vz_r); mul_req.b = {2'b00, dt};
      end
      pot_pkg::ST_KP: begin
        is_mul = 1'b1; mul_req.a = pot_pkg::MUL_AW'(e_sel); mul_req.b = {2'b00, kp_sel};
      end
      pot_pkg::ST_KD: begin
        is_mul = 1'b1; mul_req.a = pot_pkg::MUL_AW'(diff); mul_req.b = {2'b00, kd_sel};
      end
      pot_pkg::ST_FXC: begin
        is_mul = 1'b1; mul_req.a = pot_pkg::MUL_AW'(f_r[0]); mul_req.b = c_r;
      end
      pot_pkg::ST_FYS: begin
        is_mul = 1'b1; mul_req.a = pot_pkg::MUL_AW'(f_r[1]); mul_req.b = s_r;
      end
      pot_pkg::ST_FYC: begin
        is_mul = 1'b1; mul_req.a = pot_pkg::MUL_AW'(f_r[1]); mul_req.b = c_r;
      end
      pot_pkg::ST_FXS: begin
        is_mul = 1'b1; mul_req.a = pot_pkg::MUL_AW'(f_r[0]); mul_req.b = s_r;
      end
      default: begin
        is_mul = 1'b0;
      end
    endcase
    mul_req.start = is_mul && !launched_r;
    div_req.start = is_div && !launched_r;
    op_done = (is_mul && mul_rsp.done) || (is_div && div_rsp.done);
  end

  pot_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .rsp   (mul_rsp)
  );

  pot_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pot_pkg::ST_IDLE;
      launched_r  <= 1'b0;
      ax_r        <= '0;
      out_valid_r <= 1'b0;
      kpx_r <= '0; kdx_r <= '0; kpy_r <= '0; kdy_r <= '0; kpz_r <= '0; kdz_r <= '0;
      tick_r <= pot_pkg::TICK_RESET;
      est_x_r <= '0; est_y_r <= '0; est_h_r <= '0; last_yaw_r <= '0;
      goal_x_r <= '0; goal_y_r <= '0; goal_h_r <= '0;
      prev_x_r <= '0; prev_y_r <= '0; prev_h_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (mul_req.start || div_req.start) launched_r <= 1'b1;
      else if (op_done) launched_r <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          pot_pkg::CFG_GAIN_P_X:    kpx_r  <= cfg_wdata;
          pot_pkg::CFG_GAIN_D_X:    kdx_r  <= cfg_wdata;
          pot_pkg::CFG_GAIN_P_Y:    kpy_r  <= cfg_wdata;
          pot_pkg::CFG_GAIN_D_Y:    kdy_r  <= cfg_wdata;
          pot_pkg::CFG_GAIN_P_TURN: kpz_r  <= cfg_wdata;
          pot_pkg::CFG_GAIN_D_TURN: kdz_r  <= cfg_wdata;
          pot_pkg::CFG_TICK_PERIOD: tick_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (out_valid_r && !out_stall && (state_r != pot_pkg::ST_FIN)) out_valid_r <= 1'b0;
      unique case (state_r)
        pot_pkg::ST_IDLE: begin
          ax_r <= '0;
          if (in_fire && in_operation) begin
            goal_x_r <= in_target_x;
            goal_y_r <= in_target_y;
            goal_h_r <= in_target_heading;
            prev_x_r <= pot_pkg::sat32(pot_pkg::ext_t'(in_target_x) - pot_pkg::ext_t'(est_x_r));
            prev_y_r <= pot_pkg::sat32(pot_pkg::ext_t'(in_target_y) - pot_pkg::ext_t'(est_y_r));
            prev_h_r <= pot_pkg::sat32(pot_pkg::ext_t'(in_target_heading)
                                       - pot_pkg::ext_t'(est_h_r));
          end
        end
        pot_pkg::ST_TDX: if (op_done) est_x_r <= pot_pkg::sat32(pot_pkg::ext_t'(est_x_r)
            + ((pot_pkg::ext_t'(prod) + pot_pkg::HALF16) >>> 16));
        pot_pkg::ST_TDY: if (op_done) est_y_r <= pot_pkg::sat32(pot_pkg::ext_t'(est_y_r)
            + ((pot_pkg::ext_t'(prod) + pot_pkg::HALF16) >>> 16));
        pot_pkg::ST_SNAP: begin
          est_h_r    <= pot_pkg::sat32(h_snap);
          last_yaw_r <= pot_pkg::sat32(pot_pkg::ext_t'(nxt_r));
        end
        pot_pkg::ST_DDIV: begin
          if (op_done) begin
            ax_r <= ax_r + 2'd1;
            if (ax_r == AX_LAST) begin
              prev_x_r <= ex_r;
              prev_y_r <= ey_r;
              prev_h_r <= ez_r;
            end
          end
        end
        pot_pkg::ST_FIN: if (out_free) out_valid_r <= 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      pot_pkg::ST_IDLE: begin
        if (in_fire) begin
          vx_r  <= pot_pkg::sat32((pot_pkg::ext_t'(sum_x) * pot_pkg::ext_t'(pot_pkg::SCALE_X))
                                  <<< 14);
          vy_r  <= pot_pkg::sat32((pot_pkg::ext_t'(sum_y) * pot_pkg::ext_t'(pot_pkg::SCALE_Y))
                                  <<< 14);
          vz_r  <= pot_pkg::sat32((pot_pkg::ext_t'(sum_z)
                                   * pot_pkg::ext_t'(pot_pkg::SCALE_TURN)) <<< 14);
          yaw_r <= in_gyro_yaw;
        end
      end
      pot_pkg::ST_IDX1, pot_pkg::ST_IDX2: if (op_done) idx_r <= quo[pot_pkg::TRIG_BITS-1:0];
      pot_pkg::ST_LOOK1, pot_pkg::ST_LOOK2: begin
        c_r <= pot_pkg::sin_at(idx_r + pot_pkg::TRIG_BITS'(pot_pkg::TRIG_QUAD));
        s_r <= pot_pkg::sin_at(idx_r);
      end
      pot_pkg::ST_VXC, pot_pkg::ST_VYC, pot_pkg::ST_KD, pot_pkg::ST_FXC, pot_pkg::ST_FYC:
        if (op_done) p1_r <= prod;
      pot_pkg::ST_VYS: if (op_done) t_r <= TW'((pot_pkg::ext_t'(p1_r) - pot_pkg::ext_t'(prod)
                                                + pot_pkg::HALF16) >>> 16);
      pot_pkg::ST_VXS: if (op_done) t_r <= TW'((pot_pkg::ext_t'(p1_r) + pot_pkg::ext_t'(prod)
                                                + pot_pkg::HALF16) >>> 16);
      pot_pkg::ST_YAW: if (op_done) nxt_r <= TW'(yaw_unw);
      pot_pkg::ST_VZD: if (op_done) h_r <= TW'(pot_pkg::ext_t'(est_h_r)
                                  + ((pot_pkg::ext_t'(prod) + pot_pkg::HALF16) >>> 16));
      pot_pkg::ST_BLEND: if (op_done) h_r <= TW'(pot_pkg::ext_t'(h_r) + pot_pkg::ext_t'(quo));
      pot_pkg::ST_ERR: begin
        ex_r <= pot_pkg::sat32(pot_pkg::ext_t'(goal_x_r) - pot_pkg::ext_t'(est_x_r));
        ey_r <= pot_pkg::sat32(pot_pkg::ext_t'(goal_y_r) - pot_pkg::ext_t'(est_y_r));
        ez_r <= pot_pkg::sat32(pot_pkg::ext_t'(goal_h_r) - pot_pkg::ext_t'(est_h_r));
      end
      pot_pkg::ST_KP: if (op_done) pt_r <= FW'(pot_pkg::ext_t'(prod) >>> 8);
      pot_pkg::ST_DDIV: if (op_done) f_r[ax_r] <= pot_pkg::clamp40(pot_pkg::ext_t'(pt_r)
                                                                   + pot_pkg::ext_t'(quo));
      pot_pkg::ST_FYS: if (op_done) rx_r <= pot_pkg::clamp24((pot_pkg::ext_t'(p1_r)
                            + pot_pkg::ext_t'(prod) + pot_pkg::HALF32) >>> 32);
      pot_pkg::ST_FXS: if (op_done) ry_r <= pot_pkg::clamp24((pot_pkg::ext_t'(p1_r)
                            - pot_pkg::ext_t'(prod) + pot_pkg::HALF32) >>> 32);
      pot_pkg::ST_FIN: begin
        if (out_free) begin
          ocx_r <= rx_r;
          ocy_r <= ry_r;
          ocz_r <= pot_pkg::clamp24((pot_pkg::ext_t'(f_r[2]) + pot_pkg::HALF16) >>> 16);
          opx_r <= est_x_r;
          opy_r <= est_y_r;
          oph_r <= est_h_r;
        end
      end
      default: ;
    endcase
  end

  assign out_valid          = out_valid_r;
  assign out_cmd_speed_x    = ocx_r;
  assign out_cmd_speed_y    = ocy_r;
  assign out_cmd_speed_turn = ocz_r;
  assign out_pos_x          = opx_r;
  assign out_pos_y          = opy_r;
  assign out_heading        = oph_r;

  a_one_unit: assert property (@(posedge clk) disable iff (!rst_n)
    !(mul_req.start && div_req.start))
    else $error("multiplier and divider started together");

  a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == pot_pkg::ST_FIN))
    else $error("result raised outside the finish step");

  a_mul_owned: assert property (@(posedge clk) disable iff (!rst_n)
    mul_rsp.done |-> launched_r)
    else $error("multiplier finished without a launched operation");

  a_target_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_operation |=> state_r == pot_pkg::ST_IDLE && !$rose(out_valid_r))
    else $error("set target started a tick");

endmodule
